/* hw/rtl/sst_pkg.sv */
`default_nettype none

package sst_pkg;

    // widths of the running counters
    localparam int LENGTH_BITS   = 16;
    localparam int POSITION_BITS = 32;

    // result field widths (fixed by the stream format)
    localparam int CLASS_W = 6;
    localparam int START_W = 32;
    localparam int LEN_W   = 16;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // token classes; the lexer state holds the class of the pending token
    localparam logic [CLASS_W-1:0] CL_ID       = 6'd0;
    localparam logic [CLASS_W-1:0] CL_NUM      = 6'd1;
    localparam logic [CLASS_W-1:0] CL_STR      = 6'd2;
    localparam logic [CLASS_W-1:0] CL_LT       = 6'd3;
    localparam logic [CLASS_W-1:0] CL_GT       = 6'd5;
    localparam logic [CLASS_W-1:0] CL_PLUS     = 6'd7;
    localparam logic [CLASS_W-1:0] CL_PLUS_EQ  = 6'd8;
    localparam logic [CLASS_W-1:0] CL_INC      = 6'd9;
    localparam logic [CLASS_W-1:0] CL_MINUS    = 6'd10;
    localparam logic [CLASS_W-1:0] CL_MINUS_EQ = 6'd11;
    localparam logic [CLASS_W-1:0] CL_DEC      = 6'd12;
    localparam logic [CLASS_W-1:0] CL_MUL      = 6'd13;
    localparam logic [CLASS_W-1:0] CL_DIV      = 6'd15;
    localparam logic [CLASS_W-1:0] CL_DIV_EQ   = 6'd16;
    localparam logic [CLASS_W-1:0] CL_AND      = 6'd17;
    localparam logic [CLASS_W-1:0] CL_OR       = 6'd18;
    localparam logic [CLASS_W-1:0] CL_ASSIGN   = 6'd19;
    localparam logic [CLASS_W-1:0] CL_COMMA    = 6'd21;
    localparam logic [CLASS_W-1:0] CL_SEMI     = 6'd22;
    localparam logic [CLASS_W-1:0] CL_LBRACE   = 6'd23;
    localparam logic [CLASS_W-1:0] CL_RBRACE   = 6'd24;
    localparam logic [CLASS_W-1:0] CL_LBRACK   = 6'd25;
    localparam logic [CLASS_W-1:0] CL_RBRACK   = 6'd26;
    localparam logic [CLASS_W-1:0] CL_LPAREN   = 6'd27;
    localparam logic [CLASS_W-1:0] CL_RPAREN   = 6'd28;
    localparam logic [CLASS_W-1:0] CL_SQUOTE   = 6'd29;
    localparam logic [CLASS_W-1:0] CL_MOD      = 6'd30;
    localparam logic [CLASS_W-1:0] CL_LINE     = 6'd31;
    localparam logic [CLASS_W-1:0] CL_BLOCK    = 6'd32;
    localparam logic [CLASS_W-1:0] ST_IDLE     = 6'd63;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // one token as it leaves on the stream, class in the low bits
    typedef struct packed {
        logic [LEN_W-1:0]   token_length;
        logic [START_W-1:0] token_start;
        logic [CLASS_W-1:0] token_class;
    } t_token;

    typedef struct packed {
        logic   last_result;
        t_token tok;
    } t_result;

    // up to two results per character, packed from slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_emit;

    function automatic logic f_is_alpha(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic f_is_skip(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_NUL;
    endfunction

    function automatic logic [CLASS_W-1:0] f_start_class(input logic [7:0] c);
        logic [CLASS_W-1:0] cls;
        cls = CL_ID;
        if (f_is_digit(c) || c == CH_DOT) begin
            cls = CL_NUM;
        end else begin
            unique case (c)
                CH_LT:     cls = CL_LT;
                CH_GT:     cls = CL_GT;
                CH_DQUOTE: cls = CL_STR;
                CH_PLUS:   cls = CL_PLUS;
                CH_MINUS:  cls = CL_MINUS;
                CH_STAR:   cls = CL_MUL;
                CH_SLASH:  cls = CL_DIV;
                CH_AMP:    cls = CL_AND;
                CH_PIPE:   cls = CL_OR;
                CH_EQ:     cls = CL_ASSIGN;
                CH_COMMA:  cls = CL_COMMA;
                CH_SEMI:   cls = CL_SEMI;
                CH_LBRACE: cls = CL_LBRACE;
                CH_RBRACE: cls = CL_RBRACE;
                CH_LBRACK: cls = CL_LBRACK;
                CH_RBRACK: cls = CL_RBRACK;
                CH_LPAREN: cls = CL_LPAREN;
                CH_RPAREN: cls = CL_RPAREN;
                CH_SQUOTE: cls = CL_SQUOTE;
                CH_PCT:    cls = CL_MOD;
                CH_COLON:  cls = CL_MOD;
                default:   cls = CL_ID;
            endcase
        end
        return cls;
    endfunction

    // pending length as shown on the stream, limited to the field maximum
    function automatic logic [LEN_W-1:0] f_len_out(input logic [LENGTH_BITS-1:0] v);
        if (LENGTH_BITS > LEN_W && (v >> LEN_W) != '0) begin
            return '1;
        end
        return LEN_W'(v);
    endfunction

    function automatic logic [START_W-1:0] f_start_out(input logic [POSITION_BITS-1:0] v);
        return START_W'(v);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sst_lexer.sv */
`default_nettype none

module sst_lexer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_last,
    output sst_pkg::t_emit         o_emit
);

    logic [sst_pkg::CLASS_W-1:0]       r_state;
    logic                              r_star;
    logic [sst_pkg::POSITION_BITS-1:0] r_pstart;
    logic [sst_pkg::LENGTH_BITS-1:0]   r_plen;
    logic [sst_pkg::POSITION_BITS-1:0] r_pos;

    logic [sst_pkg::CLASS_W-1:0]       n_state;
    logic                              n_star;
    logic [sst_pkg::POSITION_BITS-1:0] n_pstart;
    logic [sst_pkg::LENGTH_BITS-1:0]   n_plen;

    logic [sst_pkg::CLASS_W-1:0]       st;
    logic [sst_pkg::CLASS_W-1:0]       nxt;
    logic                              ext;
    logic                              close;
    logic                              star_nx;
    logic                              idle;
    logic                              reject;
    logic                              emit_a;
    logic                              emit_b;
    logic                              start;
    logic [sst_pkg::LENGTH_BITS-1:0]   len_inc;
    logic [sst_pkg::CLASS_W-1:0]       state1;
    logic                              star1;
    logic [sst_pkg::LENGTH_BITS-1:0]   plen1;
    logic [sst_pkg::CLASS_W-1:0]       state2;
    logic [sst_pkg::POSITION_BITS-1:0] pstart2;
    logic [sst_pkg::LENGTH_BITS-1:0]   plen2;
    logic                              star2;
    sst_pkg::t_result                  res_a;
    sst_pkg::t_result                  res_b;

    // does the character extend the pending token
    always_comb begin
        st      = (r_state > sst_pkg::CL_BLOCK) ? sst_pkg::ST_IDLE : r_state;
        ext     = 1'b0;
        nxt     = st;
        close   = 1'b0;
        star_nx = r_star;
        unique case (st)
            sst_pkg::CL_ID: begin
                ext = sst_pkg::f_is_alpha(i_char) || sst_pkg::f_is_digit(i_char)
                      || i_char == sst_pkg::CH_USCORE;
            end
            sst_pkg::CL_NUM: begin
                ext = sst_pkg::f_is_digit(i_char) || i_char == sst_pkg::CH_DOT;
            end
            sst_pkg::CL_STR: begin
                ext   = 1'b1;
                close = i_char == sst_pkg::CH_DQUOTE;
            end
            sst_pkg::CL_LT, sst_pkg::CL_GT, sst_pkg::CL_MUL, sst_pkg::CL_ASSIGN: begin
                if (i_char == sst_pkg::CH_EQ) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CLASS_W'(st + 6'd1);
                end
            end
            sst_pkg::CL_PLUS: begin
                if (i_char == sst_pkg::CH_EQ) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CL_PLUS_EQ;
                end else if (i_char == sst_pkg::CH_PLUS) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CL_INC;
                end
            end
            sst_pkg::CL_MINUS: begin
                if (i_char == sst_pkg::CH_EQ) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CL_MINUS_EQ;
                end else if (i_char == sst_pkg::CH_MINUS) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CL_DEC;
                end
            end
            sst_pkg::CL_DIV: begin
                if (i_char == sst_pkg::CH_EQ) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CL_DIV_EQ;
                end else if (i_char == sst_pkg::CH_SLASH) begin
                    ext = 1'b1;
                    nxt = sst_pkg::CL_LINE;
                end else if (i_char == sst_pkg::CH_STAR) begin
                    // the opening star never counts toward the close
                    ext     = 1'b1;
                    nxt     = sst_pkg::CL_BLOCK;
                    star_nx = 1'b0;
                end
            end
            sst_pkg::CL_AND: ext = i_char == sst_pkg::CH_AMP;
            sst_pkg::CL_OR:  ext = i_char == sst_pkg::CH_PIPE;
            sst_pkg::CL_LINE: begin
                ext = !(i_char == sst_pkg::CH_LF || i_char == sst_pkg::CH_CR
                        || i_char == sst_pkg::CH_NUL);
            end
            sst_pkg::CL_BLOCK: begin
                ext = 1'b1;
                if (r_star && i_char == sst_pkg::CH_SLASH) begin
                    close = 1'b1;
                end else begin
                    star_nx = i_char == sst_pkg::CH_STAR;
                end
            end
            default: ext = 1'b0;
        endcase
    end

    always_comb begin
        idle    = st == sst_pkg::ST_IDLE;
        reject  = !idle && !ext;
        emit_a  = !idle && (!ext || close);
        len_inc = (r_plen == '1) ? r_plen : r_plen + 1'b1;

        res_a.tok.token_class  = st;
        res_a.tok.token_start  = sst_pkg::f_start_out(r_pstart);
        res_a.tok.token_length = sst_pkg::f_len_out(close ? len_inc : r_plen);

        state1 = (idle || emit_a) ? sst_pkg::ST_IDLE : nxt;
        star1  = emit_a ? 1'b0 : star_nx;
        plen1  = (idle || reject) ? r_plen : len_inc;

        // a rejected or idle-time character may open a new token
        start   = (idle || reject) && !sst_pkg::f_is_skip(i_char);
        state2  = start ? sst_pkg::f_start_class(i_char) : state1;
        pstart2 = start ? r_pos : r_pstart;
        plen2   = start ? sst_pkg::LENGTH_BITS'(1) : plen1;
        star2   = start ? 1'b0 : star1;

        emit_b = i_last && state2 != sst_pkg::ST_IDLE;

        res_a.last_result      = !emit_b;
        res_b.last_result      = 1'b1;
        res_b.tok.token_class  = state2;
        res_b.tok.token_start  = sst_pkg::f_start_out(pstart2);
        res_b.tok.token_length = sst_pkg::f_len_out(plen2);

        n_state  = emit_b ? sst_pkg::ST_IDLE : state2;
        n_star   = emit_b ? 1'b0 : star2;
        n_pstart = pstart2;
        n_plen   = plen2;

        o_emit.v0 = i_step && (emit_a || emit_b);
        o_emit.v1 = i_step && emit_a && emit_b;
        o_emit.r0 = emit_a ? res_a : res_b;
        o_emit.r1 = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sst_pkg::ST_IDLE;
            r_star   <= 1'b0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_pos    <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_star   <= n_star;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_pos    <= r_pos + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sst_out_fifo.sv */
`default_nettype none

module sst_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sst_pkg::t_emit i_emit,
    output logic               o_room2,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sst_pkg::t_result   o_data
);

    sst_pkg::t_result                r_mem [sst_pkg::FIFO_DEPTH];
    logic [sst_pkg::FIFO_AW-1:0]     r_wr;
    logic [sst_pkg::FIFO_AW-1:0]     r_rd;
    logic [sst_pkg::FIFO_CW-1:0]     r_count;
    logic                            pop;
    logic [sst_pkg::FIFO_CW-1:0]     after_pop;
    logic [sst_pkg::FIFO_CW-1:0]     n_push;

    assign o_valid   = r_count != '0;
    assign pop       = o_valid && i_ready;
    assign after_pop = r_count - sst_pkg::FIFO_CW'(pop);
    // room for a full pair of results once this cycle's pop leaves
    assign o_room2   = after_pop <= sst_pkg::FIFO_CW'(sst_pkg::FIFO_DEPTH - 2);
    assign n_push    = sst_pkg::FIFO_CW'(i_emit.v0) + sst_pkg::FIFO_CW'(i_emit.v1);
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_emit.v0) begin
            r_mem[r_wr] <= i_emit.r0;
        end
        if (i_emit.v1) begin
            r_mem[r_wr + 1'b1] <= i_emit.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + sst_pkg::FIFO_AW'(n_push);
            r_rd    <= r_rd + sst_pkg::FIFO_AW'(pop);
            r_count <= after_pop + n_push;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/shader_source_tokenizer.sv */
// Channel   Dir  tdata                         tuser  tlast
// s_axis    in   [7:0] character               -      end_of_text
// m_axis    out  [5:0] class, [37:6] start,    -      last_result
//                [53:38] length, [55:54] zero
//
// One character is taken per cycle while the queue has room for a pair of tokens. It is
// held in the input register, then the lexer step (state compare, class decode, length
// increment) writes 0, 1 or 2 tokens into a 4-entry result queue in the same cycle.
// Input stalls only while the queue cannot take a pair of tokens; a stalled
// m_axis backs up through the queue into s_axis_tready.
// Synchronous active-low reset returns the lexer to idle between tokens,
// zeroes position and pending length, and empties the queue.
`default_nettype none

module shader_source_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tlast,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [5:0] token_class, [37:6] token_start,
                                             // [53:38] token_length, [55:54] zero
    output logic             m_axis_tlast    // last_result
);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;

    logic             room2;
    logic             step;
    sst_pkg::t_emit   emit;
    sst_pkg::t_result head;

    // the held character is processed as soon as the queue has room for a pair of tokens
    assign step          = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    sst_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_emit  (emit)
    );

    sst_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = {2'b00, head.tok};
    assign m_axis_tlast = head.last_result;

endmodule

`default_nettype wire

/* hw/rtl/sst_checker.sv */
`default_nettype none

module sst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // out of reset: queue empty, input side open
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!m_axis_tvalid && s_axis_tready))
        else $error("tokenizer not empty after reset");

    // a token never has zero length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[53:38] != 16'd0))
        else $error("zero token length");

    // class code stays within the defined set, pad bits stay zero
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] <= 6'd32 && m_axis_tdata[55:54] == 2'b00))
        else $error("bad token class or pad bits");

    // a stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output transaction changed while stalled");

    // no input stall without a result waiting on the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind shader_source_tokenizer sst_checker u_sst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* sim/shader_source_tokenizer_tb.sv */
module shader_source_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1625;
    localparam int CALM_ITEMS   = 200;     // tail of the run with no idling on either side
    localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 12;
    localparam int N_DIRECTED   = 25;

    // One row of text. Rows marked typed carry a single expected token written out by
    // hand; all others are checked against the predictor.
    typedef struct packed {
        logic [7:0]                  ch;
        logic                        eot;
        logic                        typed;
        logic [sst_pkg::CLASS_W-1:0] want_cls;
        logic [sst_pkg::START_W-1:0] want_start;
        logic [sst_pkg::LEN_W-1:0]   want_len;
    } t_row;

    // Directed opening, positions counted from reset.
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{sst_pkg::CH_LC_A,   1'b1, 1'b1, sst_pkg::CL_ID,    32'd0,  16'd1},  // lone char flushed
        '{8'hFF,              1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},  // unlisted byte
        '{8'h78,              1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_DOT,    1'b0, 1'b1, sst_pkg::CL_ID,    32'd1,  16'd2},  // dot rejects
        '{sst_pkg::CH_NINE,   1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_NUL,    1'b0, 1'b1, sst_pkg::CL_NUM,   32'd3,  16'd2},  // NUL rejects
        '{sst_pkg::CH_SLASH,  1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_STAR,   1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_SLASH,  1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},  // stays open
        '{sst_pkg::CH_STAR,   1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_SLASH,  1'b0, 1'b1, sst_pkg::CL_BLOCK, 32'd6,  16'd5},
        '{sst_pkg::CH_SLASH,  1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_SLASH,  1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{8'h09,              1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},  // tab in comment
        '{sst_pkg::CH_CR,     1'b0, 1'b1, sst_pkg::CL_LINE,  32'd11, 16'd3},
        '{sst_pkg::CH_DQUOTE, 1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{8'hFF,              1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_DQUOTE, 1'b0, 1'b1, sst_pkg::CL_STR,   32'd15, 16'd3},
        '{sst_pkg::CH_LT,     1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_EQ,     1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_EQ,     1'b0, 1'b1, sst_pkg::CL_LT + 6'd1, 32'd18, 16'd2},
        '{sst_pkg::CH_AMP,    1'b0, 1'b1, sst_pkg::CL_ASSIGN, 32'd20, 16'd1},
        '{sst_pkg::CH_AMP,    1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_AMP,    1'b0, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0},
        '{sst_pkg::CH_DQUOTE, 1'b1, 1'b0, sst_pkg::CL_ID,    32'd0,  16'd0}   // two tokens
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] character
    logic        s_axis_tlast = 1'b0;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // [5:0] class, [37:6] start, [53:38] length, [55:54] 0
    logic        m_axis_tlast;          // last_result

    shader_source_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Text to send, tokens still owed by the block, and the tokens of the current character.
    t_row             text_q [$];
    sst_pkg::t_result token_q [$];
    sst_pkg::t_result fresh_q [$];

    string op_list [$] = '{"<", "<=", ">", ">=", "+", "+=", "++", "-", "-=", "--", "*", "*=",
                           "/", "/=", "&", "&&", "&&&", "|", "||", "|||", "=", "==", ",", ";",
                           "{", "}", "[", "]", "(", ")", "'", "%", ":"};

    // Lexer mirror: pending class (or idle), star flag, token start/length, running position.
    logic [sst_pkg::CLASS_W-1:0]       lx_state = sst_pkg::ST_IDLE;
    logic                              lx_star = 1'b0;
    logic [sst_pkg::POSITION_BITS-1:0] lx_start = '0;
    logic [sst_pkg::LENGTH_BITS-1:0]   lx_len = '0;
    logic [sst_pkg::POSITION_BITS-1:0] lx_pos = '0;

    // Character classes as lookup tables.
    logic [sst_pkg::CLASS_W-1:0] first_class [256];
    bit                          word_char [256];
    bit                          skip_char [256];

    int acc_idx  = 0;
    int n_errors = 0;
    int hold_at  = 32'h7FFF_FFFF;
    int pause_at = 0;
    bit calm     = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Generous ceiling: far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        for (int k = 0; k < 256; k++) begin
            first_class[k] = sst_pkg::CL_ID;
            word_char[k]   = 1'b0;
            skip_char[k]   = 1'b0;
        end
        for (int k = 0; k < 26; k++) begin
            word_char[sst_pkg::CH_LC_A + k] = 1'b1;
            word_char[sst_pkg::CH_UC_A + k] = 1'b1;
        end
        for (int k = 0; k < 10; k++) begin
            word_char[sst_pkg::CH_ZERO + k]   = 1'b1;
            first_class[sst_pkg::CH_ZERO + k] = sst_pkg::CL_NUM;
        end
        word_char[sst_pkg::CH_USCORE]    = 1'b1;
        first_class[sst_pkg::CH_DOT]     = sst_pkg::CL_NUM;
        first_class[sst_pkg::CH_LT]      = sst_pkg::CL_LT;
        first_class[sst_pkg::CH_GT]      = sst_pkg::CL_GT;
        first_class[sst_pkg::CH_DQUOTE]  = sst_pkg::CL_STR;
        first_class[sst_pkg::CH_PLUS]    = sst_pkg::CL_PLUS;
        first_class[sst_pkg::CH_MINUS]   = sst_pkg::CL_MINUS;
        first_class[sst_pkg::CH_STAR]    = sst_pkg::CL_MUL;
        first_class[sst_pkg::CH_SLASH]   = sst_pkg::CL_DIV;
        first_class[sst_pkg::CH_AMP]     = sst_pkg::CL_AND;
        first_class[sst_pkg::CH_PIPE]    = sst_pkg::CL_OR;
        first_class[sst_pkg::CH_EQ]      = sst_pkg::CL_ASSIGN;
        first_class[sst_pkg::CH_COMMA]   = sst_pkg::CL_COMMA;
        first_class[sst_pkg::CH_SEMI]    = sst_pkg::CL_SEMI;
        first_class[sst_pkg::CH_LBRACE]  = sst_pkg::CL_LBRACE;
        first_class[sst_pkg::CH_RBRACE]  = sst_pkg::CL_RBRACE;
        first_class[sst_pkg::CH_LBRACK]  = sst_pkg::CL_LBRACK;
        first_class[sst_pkg::CH_RBRACK]  = sst_pkg::CL_RBRACK;
        first_class[sst_pkg::CH_LPAREN]  = sst_pkg::CL_LPAREN;
        first_class[sst_pkg::CH_RPAREN]  = sst_pkg::CL_RPAREN;
        first_class[sst_pkg::CH_SQUOTE]  = sst_pkg::CL_SQUOTE;
        first_class[sst_pkg::CH_PCT]     = sst_pkg::CL_MOD;
        first_class[sst_pkg::CH_COLON]   = sst_pkg::CL_MOD;
        skip_char[sst_pkg::CH_SPACE]     = 1'b1;
        skip_char[sst_pkg::CH_LF]        = 1'b1;
        skip_char[sst_pkg::CH_CR]        = 1'b1;
        skip_char[sst_pkg::CH_NUL]       = 1'b1;
    end

    // ---------------------------------------------------------------- prediction

    // Close the pending token; last_result is settled once the character is done.
    task automatic emit_token();
        sst_pkg::t_result r;
        r.last_result      = 1'b0;
        r.tok.token_class  = lx_state;
        r.tok.token_start  = lx_start;
        r.tok.token_length = lx_len;
        fresh_q.push_back(r);
        lx_state = sst_pkg::ST_IDLE;
        lx_star  = 1'b0;
    endtask

    task automatic lex_char(input logic [7:0] c, input logic eot);
        logic [sst_pkg::CLASS_W-1:0]       nxt;
        logic                              rej;
        logic                              shut;
        logic                              busy;
        logic [sst_pkg::POSITION_BITS-1:0] here;
        sst_pkg::t_result                  r;
        nxt  = sst_pkg::ST_IDLE;
        rej  = 1'b0;
        shut = 1'b0;
        here = lx_pos;
        lx_pos = lx_pos + 1'b1;
        if (lx_state > sst_pkg::CL_BLOCK) begin
            lx_state = sst_pkg::ST_IDLE;
        end
        busy = (lx_state != sst_pkg::ST_IDLE);
        if (busy) begin
            case (lx_state)
                sst_pkg::CL_ID: begin
                    if (word_char[c]) nxt = lx_state; else rej = 1'b1;
                end
                sst_pkg::CL_NUM: begin
                    if (first_class[c] == sst_pkg::CL_NUM) nxt = lx_state; else rej = 1'b1;
                end
                sst_pkg::CL_STR: begin
                    nxt  = lx_state;
                    shut = (c == sst_pkg::CH_DQUOTE);
                end
                sst_pkg::CL_LT, sst_pkg::CL_GT, sst_pkg::CL_MUL, sst_pkg::CL_ASSIGN: begin
                    // the '=' form is the next class up
                    if (c == sst_pkg::CH_EQ) nxt = lx_state + 6'd1; else rej = 1'b1;
                end
                sst_pkg::CL_PLUS: begin
                    if (c == sst_pkg::CH_EQ) nxt = sst_pkg::CL_PLUS_EQ;
                    else if (c == sst_pkg::CH_PLUS) nxt = sst_pkg::CL_INC;
                    else rej = 1'b1;
                end
                sst_pkg::CL_MINUS: begin
                    if (c == sst_pkg::CH_EQ) nxt = sst_pkg::CL_MINUS_EQ;
                    else if (c == sst_pkg::CH_MINUS) nxt = sst_pkg::CL_DEC;
                    else rej = 1'b1;
                end
                sst_pkg::CL_DIV: begin
                    if (c == sst_pkg::CH_EQ) begin
                        nxt = sst_pkg::CL_DIV_EQ;
                    end else if (c == sst_pkg::CH_SLASH) begin
                        nxt = sst_pkg::CL_LINE;
                    end else if (c == sst_pkg::CH_STAR) begin
                        nxt     = sst_pkg::CL_BLOCK;
                        lx_star = 1'b0;     // the opening star never closes
                    end else begin
                        rej = 1'b1;
                    end
                end
                sst_pkg::CL_AND: begin
                    if (c == sst_pkg::CH_AMP) nxt = lx_state; else rej = 1'b1;
                end
                sst_pkg::CL_OR: begin
                    if (c == sst_pkg::CH_PIPE) nxt = lx_state; else rej = 1'b1;
                end
                sst_pkg::CL_LINE: begin
                    if (c == sst_pkg::CH_LF || c == sst_pkg::CH_CR || c == sst_pkg::CH_NUL)
                        rej = 1'b1;
                    else
                        nxt = lx_state;
                end
                sst_pkg::CL_BLOCK: begin
                    nxt = lx_state;
                    if (lx_star && c == sst_pkg::CH_SLASH) shut = 1'b1;
                    else lx_star = (c == sst_pkg::CH_STAR);
                end
                default: rej = 1'b1;
            endcase
            if (rej) begin
                emit_token();
            end else begin
                if (lx_len != {sst_pkg::LENGTH_BITS{1'b1}}) lx_len = lx_len + 1'b1;
                if (shut) emit_token(); else lx_state = nxt;
            end
        end
        // a rejected character gets a second look from idle
        if ((!busy || rej) && !skip_char[c]) begin
            lx_state = first_class[c];
            lx_start = here;
            lx_len   = 1;
            lx_star  = 1'b0;
        end
        if (eot && lx_state != sst_pkg::ST_IDLE) begin
            emit_token();
        end
        if (fresh_q.size() != 0) begin
            r = fresh_q.pop_back();
            r.last_result = 1'b1;
            fresh_q.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- text building

    task automatic push_char(input logic [7:0] c);
        t_row r;
        r = '{c, 1'b0, 1'b0, sst_pkg::CL_ID, 32'd0, 16'd0};
        text_q.push_back(r);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k]);
        end
    endtask

    task automatic set_end_on_last();
        t_row r;
        r = text_q.pop_back();
        r.eot = 1'b1;
        text_q.push_back(r);
    endtask

    function automatic logic [7:0] rand_word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'(sst_pkg::CH_LC_A + r);
        if (r < 52) return 8'(sst_pkg::CH_UC_A + r - 26);
        if (r == 52) return sst_pkg::CH_USCORE;
        return 8'(sst_pkg::CH_ZERO + r - 53);
    endfunction

    // One well-formed token with random content, or a noise byte, then at times a separator.
    task automatic push_random_token();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: begin
                push_char(rand_word_char(1'b1));
                repeat ($urandom_range(0, 7)) push_char(rand_word_char(1'b0));
            end
            2: begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 4) == 0) push_char(sst_pkg::CH_DOT);
                    else push_char(8'(sst_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
            end
            3: begin
                push_char(sst_pkg::CH_DQUOTE);
                repeat ($urandom_range(0, 6)) begin
                    c = 8'($urandom_range(0, 255));
                    push_char(c == sst_pkg::CH_DQUOTE ? sst_pkg::CH_UC_A : c);
                end
                // now and then the text ends inside the string
                if ($urandom_range(0, 7) == 0) set_end_on_last();
                else push_char(sst_pkg::CH_DQUOTE);
            end
            4, 5, 6: push_text(op_list[$urandom_range(0, op_list.size() - 1)]);
            7: begin
                push_text("//");
                repeat ($urandom_range(0, 8)) begin
                    c = 8'($urandom_range(0, 255));
                    push_char(skip_char[c] && c != sst_pkg::CH_SPACE ? 8'h78 : c);
                end
                case ($urandom_range(0, 2))
                    0: push_char(sst_pkg::CH_LF);
                    1: push_char(sst_pkg::CH_CR);
                    default: push_char(sst_pkg::CH_NUL);
                endcase
            end
            8: begin
                // body mixes stars and slashes so the close is hit early at times
                push_text("/*");
                repeat ($urandom_range(0, 8)) begin
                    case ($urandom_range(0, 4))
                        0: push_char(sst_pkg::CH_LC_A);
                        1: push_char(sst_pkg::CH_STAR);
                        2: push_char(sst_pkg::CH_SLASH);
                        3: push_char(sst_pkg::CH_SPACE);
                        default: push_char(8'hFF);
                    endcase
                end
                push_text("*/");
            end
            default: push_char(8'($urandom_range(0, 255)));
        endcase
        case ($urandom_range(0, 6))
            2: push_char(sst_pkg::CH_SPACE);
            3: push_char(sst_pkg::CH_LF);
            4: push_char(8'h09);
            5: push_char(sst_pkg::CH_CR);
            6: push_char(sst_pkg::CH_NUL);
            default: ;
        endcase
        if ($urandom_range(0, 29) == 0) set_end_on_last();
    endtask

    // ---------------------------------------------------------------- sender

    initial begin
        int rand_base;
        for (int k = 0; k < N_DIRECTED; k++) begin
            text_q.push_back(DIRECTED[k]);
        end
        pause_at = text_q.size();

        rand_base = text_q.size();
        hold_at   = rand_base + 300;
        while (text_q.size() - rand_base < RANDOM_ITEMS) begin
            push_random_token();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < text_q.size(); idx++) begin
            calm = (idx >= text_q.size() - CALM_ITEMS);
            if (idx == pause_at) begin
                // sender waits until every owed token has come out
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (token_q.size() != 0);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_q[idx].ch;
            s_axis_tlast  <= text_q[idx].eot;
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (token_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        bit held;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && acc_idx > hold_at) begin
                // long hold-off: queue fills and s_axis_tready must drop
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_field(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        n_errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    endtask

    // Output transactions are checked before the input transaction of the same edge is
    // predicted; the block's latency keeps the two apart.
    always @(posedge i_clk) begin
        sst_pkg::t_result want;
        t_row             row;
        if (!i_rst_n) begin
            lx_state = sst_pkg::ST_IDLE;
            lx_star  = 1'b0;
            lx_start = '0;
            lx_len   = '0;
            lx_pos   = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (token_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: token mismatch, expected none, actual %h", $time,
                             m_axis_tdata);
                end else begin
                    want = token_q.pop_front();
                    if (m_axis_tdata[5:0] !== want.tok.token_class)
                        report_field("token_class", 32'(want.tok.token_class),
                                     32'(m_axis_tdata[5:0]));
                    if (m_axis_tdata[37:6] !== want.tok.token_start)
                        report_field("token_start", want.tok.token_start, m_axis_tdata[37:6]);
                    if (m_axis_tdata[53:38] !== want.tok.token_length)
                        report_field("token_length", 32'(want.tok.token_length),
                                     32'(m_axis_tdata[53:38]));
                    if (m_axis_tdata[55:54] !== 2'b00)
                        report_field("tdata pad", 32'd0, 32'(m_axis_tdata[55:54]));
                    if (m_axis_tlast !== want.last_result)
                        report_field("last_result", 32'(want.last_result), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                fresh_q.delete();
                lex_char(s_axis_tdata, s_axis_tlast);
                row = text_q[acc_idx];
                if (row.typed) begin
                    want.last_result      = 1'b1;
                    want.tok.token_class  = row.want_cls;
                    want.tok.token_start  = row.want_start;
                    want.tok.token_length = row.want_len;
                    token_q.push_back(want);
                end else begin
                    foreach (fresh_q[k]) token_q.push_back(fresh_q[k]);
                end
                acc_idx++;
            end
        end
    end

endmodule
